### rtl/utu_pkg.sv
// ----------------------------------------------------------------------------
// utu_pkg
// Shared types and constants of the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package utu_pkg;

  localparam int unsigned MaxBytesDef = 255;
  localparam int unsigned UnitW       = 16;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned BurstMax    = 4;
  localparam int unsigned LenW        = $clog2(BurstMax + 1);

  // The upper six bits of a UTF-16 unit tell surrogates apart.
  localparam logic [5:0] HighTag = 6'h36;
  localparam logic [5:0] LowTag  = 6'h37;

  localparam logic [ByteW-1:0] SubstChar = 8'h3F;  // '?'
  localparam logic [ByteW-1:0] NulChar   = 8'h00;

  // Bytes produced for one code unit, sent from index 0 upward.
  typedef struct packed {
    logic [BurstMax-1:0][ByteW-1:0] bytes;
    logic [LenW-1:0]                len;
    logic                           last;  // final byte of the burst ends the name
  } burst_t;

endpackage

### rtl/utf16_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Converts a stream of UTF-16 code units of a name into UTF-8 bytes.
// ----------------------------------------------------------------------------
// The slave channel takes one 16-bit UTF-16 code unit per transfer; a zero
// unit ends the name. The master channel sends one UTF-8 byte per transfer,
// and the NUL byte that ends a name carries tlast.
// A unit is captured in an input register, encoded combinationally into a
// burst of zero to four bytes, and parked in the output buffer, which sends
// one byte per cycle while the receiver is ready. The first byte of a unit
// passes the input register and the output buffer before it shows on the
// master side. A unit makes one byte for ASCII and up to four for a
// surrogate pair. A unit that makes no byte (a held high surrogate, or any
// unit but the terminator once the name is full) leaves the buffer free.
// The next unit is taken into the input register while the buffer still
// sends, and moves on in the cycle the buffer's last byte is taken.
// When the receiver stalls, the buffer holds its byte and the input
// register fills; tready then drops until the buffer drains.
// Reset clears the held surrogate, the byte count and both stages; every
// name is limited to MaxBytes bytes, not counting the NUL.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder #(
  parameter int unsigned MaxBytes = utu_pkg::MaxBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [utu_pkg::UnitW-1:0]   s_axis_tdata_i,   // [15:0] code_unit
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [utu_pkg::ByteW-1:0]   m_axis_tdata_o,   // [7:0] out_byte
  output logic                        m_axis_tlast_o
);

  logic                       in_valid_q;
  logic [utu_pkg::UnitW-1:0]  in_unit_q;
  logic                       ser_free;
  logic                       advance;
  utu_pkg::burst_t            burst;

  // The unit moves into the encoder state and the output buffer together.
  assign advance         = in_valid_q && ser_free;
  assign s_axis_tready_o = !in_valid_q || ser_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_unit_q <= s_axis_tdata_i;
    end
  end

  utu_encoder #(
    .MaxBytes (MaxBytes)
  ) u_encoder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .unit_i    (in_unit_q),
    .burst_o   (burst)
  );

  utu_serializer u_serializer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance),
    .burst_i         (burst),
    .free_o          (ser_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

### rtl/utu_encoder.sv
// ----------------------------------------------------------------------------
// utu_encoder
// Surrogate pairing, byte limit and UTF-8 encoding of one code unit.
// ----------------------------------------------------------------------------
module utu_encoder #(
  parameter int unsigned MaxBytes = utu_pkg::MaxBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  logic [utu_pkg::UnitW-1:0]   unit_i,
  output utu_pkg::burst_t             burst_o
);

  localparam int unsigned CntW = $clog2(MaxBytes + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxBytes);

  logic [9:0]      pend_high_q, pend_high_d;
  logic            pend_valid_q, pend_valid_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [5:0]      tag;
  logic [20:0]     cp;
  logic [20:0]     surr_cp;
  logic            full;
  logic            do_emit;
  logic            term;
  logic [2:0]      n;
  logic [CntW:0]   sum;
  logic            fit;

  assign tag     = unit_i[15:10];
  assign surr_cp = 21'h10000 + {1'b0, pend_high_q, unit_i[9:0]};
  assign full    = cnt_q >= MaxCnt;

  always_comb begin
    cp           = {13'd0, utu_pkg::SubstChar};
    do_emit      = 1'b0;
    term         = 1'b0;
    pend_high_d  = pend_high_q;
    pend_valid_d = pend_valid_q;
    if (unit_i == '0) begin
      do_emit = pend_valid_q && !full;
      term    = 1'b1;
    end else if (full) begin
      do_emit = 1'b0;
    end else if (pend_valid_q) begin
      if (tag == utu_pkg::LowTag) begin
        cp = surr_cp;
      end
      do_emit      = 1'b1;
      pend_valid_d = 1'b0;
      pend_high_d  = '0;
    end else if (tag == utu_pkg::HighTag) begin
      pend_valid_d = 1'b1;
      pend_high_d  = unit_i[9:0];
    end else begin
      cp      = {5'd0, unit_i};
      do_emit = 1'b1;
    end
  end

  always_comb begin
    if (cp < 21'h80) begin
      n = 3'd1;
    end else if (cp < 21'h800) begin
      n = 3'd2;
    end else if (cp < 21'h10000) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
  end

  assign sum = {1'b0, cnt_q} + (CntW + 1)'(n);
  assign fit = sum <= {1'b0, MaxCnt};

  always_comb begin
    burst_o = '0;
    cnt_d   = cnt_q;
    if (do_emit) begin
      if (fit) begin
        cnt_d       = sum[CntW-1:0];
        burst_o.len = n;
        unique case (n)
          3'd1: burst_o.bytes[0] = cp[7:0];
          3'd2: begin
            burst_o.bytes[0] = {3'b110, cp[10:6]};
            burst_o.bytes[1] = {2'b10, cp[5:0]};
          end
          3'd3: begin
            burst_o.bytes[0] = {4'b1110, cp[15:12]};
            burst_o.bytes[1] = {2'b10, cp[11:6]};
            burst_o.bytes[2] = {2'b10, cp[5:0]};
          end
          default: begin
            burst_o.bytes[0] = {5'b11110, cp[20:18]};
            burst_o.bytes[1] = {2'b10, cp[17:12]};
            burst_o.bytes[2] = {2'b10, cp[11:6]};
            burst_o.bytes[3] = {2'b10, cp[5:0]};
          end
        endcase
      end else begin
        // A sequence that does not fit fills the name.
        cnt_d = MaxCnt;
      end
    end
    if (term) begin
      // At most the substitute byte precedes the NUL, so the index stays small.
      burst_o.bytes[burst_o.len[1:0]] = utu_pkg::NulChar;
      burst_o.len  = burst_o.len + 3'd1;
      burst_o.last = 1'b1;
      cnt_d        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_high_q  <= '0;
      pend_valid_q <= 1'b0;
      cnt_q        <= '0;
    end else if (advance_i) begin
      pend_high_q  <= term ? 10'd0 : pend_high_d;
      pend_valid_q <= term ? 1'b0 : pend_valid_d;
      cnt_q        <= cnt_d;
    end
  end

endmodule

### rtl/utu_serializer.sv
// ----------------------------------------------------------------------------
// utu_serializer
// Holds the bytes of one code unit and sends them one per transfer.
// ----------------------------------------------------------------------------
module utu_serializer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  utu_pkg::burst_t             burst_i,
  output logic                        free_o,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [utu_pkg::ByteW-1:0]   m_axis_tdata_o,
  output logic                        m_axis_tlast_o
);

  logic                                           valid_q;
  logic [1:0]                                     idx_q;
  logic [utu_pkg::LenW-1:0]                       len_q;
  logic                                           last_q;
  logic [utu_pkg::BurstMax-1:0][utu_pkg::ByteW-1:0] bytes_q;
  logic                                           final_byte;

  assign final_byte      = {1'b0, idx_q} == (len_q - 3'd1);
  assign free_o          = !valid_q || (m_axis_tready_i && final_byte);
  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = bytes_q[idx_q];
  assign m_axis_tlast_o  = last_q && final_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
      len_q   <= '0;
      last_q  <= 1'b0;
    end else if (load_i) begin
      valid_q <= burst_i.len != '0;
      idx_q   <= '0;
      len_q   <= burst_i.len;
      last_q  <= burst_i.last;
    end else if (valid_q && m_axis_tready_i) begin
      if (final_byte) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= burst_i.bytes;
    end
  end

endmodule

### rtl/utu_checker.sv
// ----------------------------------------------------------------------------
// utu_checker
// Port-level checks of the transcoder, bound to the top level.
// ----------------------------------------------------------------------------
module utu_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid_i,
  input logic                        s_axis_tready_o,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [utu_pkg::ByteW-1:0]   m_axis_tdata_o,
  input logic                        m_axis_tlast_o
);

  // A stalled output byte stays put until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output transfer changed while stalled");

  // Only the terminator is a zero byte, and it always ends the name.
  a_nul_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tdata_o == utu_pkg::NulChar) == m_axis_tlast_o))
    else $error("zero byte and tlast disagree");

  // Nothing can reach the output in the first cycle out of reset.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid right after reset");

  // With an empty pipeline the input side is open.
  a_ready_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tvalid_i && !m_axis_tvalid_o ##1 !s_axis_tvalid_i && !m_axis_tvalid_o
      |-> s_axis_tready_o)
    else $error("input stalled with nothing in flight");

endmodule

bind utf16_to_utf8_transcoder utu_checker u_utu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
